[rtl/core/rau_pkg.sv]
// Shared constants for the rational arithmetic unit.
// Action codes, compare order codes and stream field widths.
// No dependencies.
package rau_pkg;

    localparam int DEFAULT_WIDTH = 32;

    // fixed field widths on the stream ports
    localparam int NUM_W       = 32;
    localparam int ACT_W       = 3;
    localparam int ORD_W       = 2;
    localparam int S_TDATA_W   = 128;
    localparam int M_TDATA_W   = 72;

    localparam logic [ACT_W-1:0] ACT_ADD = 3'd0;
    localparam logic [ACT_W-1:0] ACT_SUB = 3'd1;
    localparam logic [ACT_W-1:0] ACT_MUL = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DIV = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RED = 3'd4;
    localparam logic [ACT_W-1:0] ACT_CMP = 3'd5;

    localparam logic [ORD_W-1:0] ORD_LESS    = 2'd0;
    localparam logic [ORD_W-1:0] ORD_EQUAL   = 2'd1;
    localparam logic [ORD_W-1:0] ORD_GREATER = 2'd2;

endpackage

[rtl/core/rau_div.sv]
// Iterative restoring divider: unsigned quotient and remainder, one bit per cycle.
// Depends on rau_pkg for the default width. Divisor must be nonzero.
module rau_div #(
    parameter int WIDTH = rau_pkg::DEFAULT_WIDTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder
);
    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [WIDTH:0] shifted;
    logic [WIDTH:0] diff;

    always_comb begin
        shifted   = {rem_reg, quo_reg[WIDTH-1]};
        diff      = shifted - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[WIDTH]) begin
                rem_next = diff[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end else begin
                rem_next = shifted[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WIDTH - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[rtl/core/rau_mul.sv]
// Registered multiplier: low WIDTH bits of the product, valid in the cycle after start.
// Depends on rau_pkg for the default width.
module rau_mul #(
    parameter int WIDTH = rau_pkg::DEFAULT_WIDTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] op_a,
    input  logic [WIDTH-1:0] op_b,
    output logic             valid,
    output logic [WIDTH-1:0] product
);
    logic [2*WIDTH-1:0] full;
    logic [WIDTH-1:0]   prod_reg;
    logic               valid_reg;

    // low bits are the same for signed and unsigned operands
    assign full = op_a * op_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= start;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            prod_reg <= full[WIDTH-1:0];
        end
    end

    assign valid   = valid_reg;
    assign product = prod_reg;

endmodule

[rtl/core/rational_arithmetic_unit_top.sv]
// Rational arithmetic unit: add, subtract, multiply, divide, reduce, compare.
// Add/sub/cmp run Euclid's gcd on the denominators, then the lcm and scaled numerators;
// reduce divides |num| and den by their gcd; mul/div use two multiplies; a zero den
// on add/sub/cmp or a no-op action goes straight to S_DONE. One beat in flight at a time.
// Reset: aresetn synchronous active low; clears sequencer and valid flags only.
// Depends on rau_pkg, rau_div, rau_mul.
module rational_arithmetic_unit_top #(
    parameter int WIDTH = rau_pkg::DEFAULT_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // a_num, a_den, b_num, b_den
    input  logic [rau_pkg::S_TDATA_W-1:0]  s_tdata,
    // action
    input  logic [rau_pkg::ACT_W-1:0]      s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // r_num, r_den, order, zero padding
    output logic [rau_pkg::M_TDATA_W-1:0]  m_tdata,
    // zero_den_error
    output logic                           m_tuser
);
    import rau_pkg::*;

    localparam int ST_W = 5;
    localparam logic [ST_W-1:0] S_IDLE   = 5'd0;
    localparam logic [ST_W-1:0] S_DISP   = 5'd1;
    localparam logic [ST_W-1:0] S_GCD    = 5'd2;
    localparam logic [ST_W-1:0] S_GCD_W  = 5'd3;
    localparam logic [ST_W-1:0] S_LCM_D  = 5'd4;
    localparam logic [ST_W-1:0] S_LCM_M  = 5'd5;
    localparam logic [ST_W-1:0] S_N1_D   = 5'd6;
    localparam logic [ST_W-1:0] S_N1_M   = 5'd7;
    localparam logic [ST_W-1:0] S_N2_D   = 5'd8;
    localparam logic [ST_W-1:0] S_N2_M   = 5'd9;
    localparam logic [ST_W-1:0] S_MUL_A  = 5'd10;
    localparam logic [ST_W-1:0] S_MUL_B  = 5'd11;
    localparam logic [ST_W-1:0] S_RED_N  = 5'd12;
    localparam logic [ST_W-1:0] S_RED_D  = 5'd13;
    localparam logic [ST_W-1:0] S_DONE   = 5'd14;

    logic [ST_W-1:0]  state_reg, state_next;
    logic [ACT_W-1:0] act_reg, act_next;
    logic [WIDTH-1:0] an_reg, an_next, ad_reg, ad_next;
    logic [WIDTH-1:0] bn_reg, bn_next, bd_reg, bd_next;
    logic [WIDTH-1:0] x_reg, x_next, y_reg, y_next;
    logic [WIDTH-1:0] l_reg, l_next, n1_reg, n1_next;
    logic [WIDTH-1:0] rn_reg, rn_next, rd_reg, rd_next;
    logic [ORD_W-1:0] ord_reg, ord_next;
    logic             err_reg, err_next;

    logic             m_valid_reg, m_valid_next;
    logic [NUM_W-1:0] m_num_reg, m_num_next, m_den_reg, m_den_next;
    logic [ORD_W-1:0] m_ord_reg, m_ord_next;
    logic             m_err_reg, m_err_next;

    logic             div_start, div_done;
    logic [WIDTH-1:0] div_a, div_b, div_q, div_r;
    logic             mul_start, mul_valid;
    logic [WIDTH-1:0] mul_a, mul_b, mul_p;

    logic [WIDTH-1:0] an_mag, bn_mag, sum, dif;
    logic             an_neg, bn_neg;

    rau_div #(.WIDTH(WIDTH)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    rau_mul #(.WIDTH(WIDTH)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .valid   (mul_valid),
        .product (mul_p)
    );

    assign an_neg = an_reg[WIDTH-1];
    assign bn_neg = bn_reg[WIDTH-1];
    assign an_mag = an_neg ? (WIDTH'(0) - an_reg) : an_reg;
    assign bn_mag = bn_neg ? (WIDTH'(0) - bn_reg) : bn_reg;
    assign sum    = n1_reg + mul_p;
    assign dif    = n1_reg - mul_p;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        act_next     = act_reg;
        an_next      = an_reg;
        ad_next      = ad_reg;
        bn_next      = bn_reg;
        bd_next      = bd_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        l_next       = l_reg;
        n1_next      = n1_reg;
        rn_next      = rn_reg;
        rd_next      = rd_reg;
        ord_next     = ord_reg;
        err_next     = err_reg;
        m_valid_next = m_valid_reg;
        m_num_next   = m_num_reg;
        m_den_next   = m_den_reg;
        m_ord_next   = m_ord_reg;
        m_err_next   = m_err_reg;
        div_start    = 1'b0;
        div_a        = x_reg;
        div_b        = y_reg;
        mul_start    = 1'b0;
        mul_a        = an_reg;
        mul_b        = bn_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    act_next   = s_tuser;
                    an_next    = s_tdata[0 +: WIDTH];
                    ad_next    = s_tdata[NUM_W +: WIDTH];
                    bn_next    = s_tdata[2*NUM_W +: WIDTH];
                    bd_next    = s_tdata[3*NUM_W +: WIDTH];
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                rn_next  = '0;
                rd_next  = '0;
                ord_next = ORD_LESS;
                err_next = 1'b0;
                priority if (act_reg == ACT_ADD || act_reg == ACT_SUB
                             || act_reg == ACT_CMP) begin
                    if (ad_reg == '0 || bd_reg == '0) begin
                        // no common denominator
                        err_next   = 1'b1;
                        ord_next   = (act_reg == ACT_CMP) ? ORD_EQUAL : ORD_LESS;
                        state_next = S_DONE;
                    end else begin
                        x_next     = ad_reg;
                        y_next     = bd_reg;
                        state_next = S_GCD;
                    end
                end else if (act_reg == ACT_MUL) begin
                    mul_start  = 1'b1;
                    mul_a      = an_reg;
                    mul_b      = bn_reg;
                    state_next = S_MUL_A;
                end else if (act_reg == ACT_DIV) begin
                    mul_start  = 1'b1;
                    mul_a      = an_reg;
                    mul_b      = bd_reg;
                    state_next = S_MUL_A;
                end else if (act_reg == ACT_RED) begin
                    x_next     = an_mag;
                    y_next     = ad_reg;
                    state_next = S_GCD;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_GCD: begin
                if (y_reg != '0) begin
                    div_start  = 1'b1;
                    div_a      = x_reg;
                    div_b      = y_reg;
                    state_next = S_GCD_W;
                end else if (act_reg == ACT_RED) begin
                    if (x_reg == '0) begin
                        err_next   = 1'b1;
                        state_next = S_DONE;
                    end else begin
                        div_start  = 1'b1;
                        div_a      = an_mag;
                        div_b      = x_reg;
                        state_next = S_RED_N;
                    end
                end else begin
                    div_start  = 1'b1;
                    div_a      = ad_reg;
                    div_b      = x_reg;
                    state_next = S_LCM_D;
                end
            end
            S_GCD_W: begin
                if (div_done) begin
                    x_next     = y_reg;
                    y_next     = div_r;
                    state_next = S_GCD;
                end
            end
            S_LCM_D: begin
                if (div_done) begin
                    mul_start  = 1'b1;
                    mul_a      = div_q;
                    mul_b      = bd_reg;
                    state_next = S_LCM_M;
                end
            end
            S_LCM_M: begin
                if (mul_valid) begin
                    l_next     = mul_p;
                    div_start  = 1'b1;
                    div_a      = mul_p;
                    div_b      = ad_reg;
                    state_next = S_N1_D;
                end
            end
            S_N1_D: begin
                if (div_done) begin
                    mul_start  = 1'b1;
                    mul_a      = div_q;
                    mul_b      = an_reg;
                    state_next = S_N1_M;
                end
            end
            S_N1_M: begin
                if (mul_valid) begin
                    n1_next    = mul_p;
                    div_start  = 1'b1;
                    div_a      = l_reg;
                    div_b      = bd_reg;
                    state_next = S_N2_D;
                end
            end
            S_N2_D: begin
                if (div_done) begin
                    mul_start  = 1'b1;
                    mul_a      = div_q;
                    mul_b      = bn_reg;
                    state_next = S_N2_M;
                end
            end
            S_N2_M: begin
                if (mul_valid) begin
                    rn_next  = (act_reg == ACT_ADD) ? sum : dif;
                    rd_next  = l_reg;
                    err_next = (l_reg == '0);
                    if (act_reg == ACT_CMP) begin
                        if (dif == '0) begin
                            ord_next = ORD_EQUAL;
                        end else if (dif[WIDTH-1]) begin
                            ord_next = ORD_LESS;
                        end else begin
                            ord_next = ORD_GREATER;
                        end
                    end
                    state_next = S_DONE;
                end
            end
            S_MUL_A: begin
                if (mul_valid) begin
                    n1_next    = mul_p;
                    mul_start  = 1'b1;
                    mul_a      = ad_reg;
                    mul_b      = (act_reg == ACT_DIV) ? bn_mag : bd_reg;
                    state_next = S_MUL_B;
                end
            end
            S_MUL_B: begin
                if (mul_valid) begin
                    rd_next    = mul_p;
                    rn_next    = (act_reg == ACT_DIV && bn_neg)
                                 ? (WIDTH'(0) - n1_reg) : n1_reg;
                    err_next   = (mul_p == '0);
                    state_next = S_DONE;
                end
            end
            S_RED_N: begin
                if (div_done) begin
                    n1_next    = an_neg ? (WIDTH'(0) - div_q) : div_q;
                    div_start  = 1'b1;
                    div_a      = ad_reg;
                    div_b      = x_reg;
                    state_next = S_RED_D;
                end
            end
            S_RED_D: begin
                if (div_done) begin
                    rn_next    = n1_reg;
                    rd_next    = div_q;
                    err_next   = (div_q == '0);
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_num_next   = NUM_W'($signed(rn_reg));
                    m_den_next   = NUM_W'(rd_reg);
                    m_ord_next   = ord_reg;
                    m_err_next   = err_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg   <= act_next;
        an_reg    <= an_next;
        ad_reg    <= ad_next;
        bn_reg    <= bn_next;
        bd_reg    <= bd_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        l_reg     <= l_next;
        n1_reg    <= n1_next;
        rn_reg    <= rn_next;
        rd_reg    <= rd_next;
        ord_reg   <= ord_next;
        err_reg   <= err_next;
        m_num_reg <= m_num_next;
        m_den_reg <= m_den_next;
        m_ord_reg <= m_ord_next;
        m_err_reg <= m_err_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - 2*NUM_W - ORD_W){1'b0}}, m_ord_reg, m_den_reg, m_num_reg};
    assign m_tuser  = m_err_reg;

endmodule

[bench/rational_arithmetic_unit_top_tb.sv]
// Self-checking bench for rational_arithmetic_unit_top: directed corner cases, random
// operands under three idle mixes and a long output stall, each result checked per field.
// Depends on rau_pkg and the RTL of the unit.
module rational_arithmetic_unit_top_tb;
    import rau_pkg::*;

    // action codes the unit treats as no operation
    localparam logic [ACT_W-1:0] ACT_RSVD6 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_RSVD7 = 3'd7;

    localparam int QUIET_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 2000;

    typedef struct packed {
        logic [NUM_W-1:0] r_num;
        logic [NUM_W-1:0] r_den;
        logic [ORD_W-1:0] order;
        logic             err;
    } rational_result_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // a_num, a_den, b_num, b_den
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    // action
    logic [ACT_W-1:0]     s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // r_num, r_den, order, zero padding
    logic [M_TDATA_W-1:0] m_tdata;
    // zero_den_error
    logic                 m_tuser;

    rational_result_t pending_results[$];
    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int stall_request  = 0;
    int stall_left     = 0;
    int quiet_cycles   = 0;

    rational_arithmetic_unit_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic logic [NUM_W-1:0] gcd_of(logic [NUM_W-1:0] x, logic [NUM_W-1:0] y);
        logic [NUM_W-1:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic logic [NUM_W-1:0] abs_num(logic [NUM_W-1:0] v);
        return v[NUM_W-1] ? -v : v;
    endfunction

    // 32-bit unsigned arithmetic wraps exactly like the datapath
    function automatic rational_result_t rational_eval(logic [ACT_W-1:0] act,
            logic [NUM_W-1:0] an, logic [NUM_W-1:0] ad,
            logic [NUM_W-1:0] bn, logic [NUM_W-1:0] bd);
        rational_result_t r;
        logic [NUM_W-1:0] g, l, n1, n2;
        r = '0;
        case (act)
            ACT_ADD, ACT_SUB, ACT_CMP: begin
                if (ad == 0 || bd == 0) begin
                    r.err = 1'b1;
                    if (act == ACT_CMP) r.order = ORD_EQUAL;
                end else begin
                    g  = gcd_of(ad, bd);
                    l  = (ad / g) * bd;
                    n1 = (l / ad) * an;
                    n2 = (l / bd) * bn;
                    r.r_num = (act == ACT_ADD) ? n1 + n2 : n1 - n2;
                    r.r_den = l;
                    r.err   = (l == 0);
                    if (act == ACT_CMP) begin
                        if (r.r_num == 0) r.order = ORD_EQUAL;
                        else if (r.r_num[NUM_W-1]) r.order = ORD_LESS;
                        else r.order = ORD_GREATER;
                    end
                end
            end
            ACT_MUL: begin
                r.r_num = an * bn;
                r.r_den = ad * bd;
                r.err   = (r.r_den == 0);
            end
            ACT_DIV: begin
                r.r_num = an * bd;
                r.r_den = ad * abs_num(bn);
                if (bn[NUM_W-1]) r.r_num = -r.r_num;
                r.err   = (r.r_den == 0);
            end
            ACT_RED: begin
                g = gcd_of(abs_num(an), ad);
                if (g == 0) begin
                    r.err = 1'b1;
                end else begin
                    r.r_num = abs_num(an) / g;
                    if (an[NUM_W-1]) r.r_num = -r.r_num;
                    r.r_den = ad / g;
                    r.err   = (r.r_den == 0);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [NUM_W-1:0] got, logic [NUM_W-1:0] want);
        $display("mismatch %s: got %h, want %h", what, got, want);
        mismatch_count++;
    endtask

    // holds until the beat is taken, then queues its predicted result
    task automatic send_operands(logic [ACT_W-1:0] act, logic [NUM_W-1:0] an,
            logic [NUM_W-1:0] ad, logic [NUM_W-1:0] bn, logic [NUM_W-1:0] bd);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {bd, bn, ad, an};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(rational_eval(act, an, ad, bn, bd));
    endtask

    task automatic end_stream();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [NUM_W-1:0] pick_num();
        case ($urandom_range(9))
            0, 1:    return $urandom;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return '0;
            default: return 32'($urandom_range(120)) - 32'd60;
        endcase
    endfunction

    function automatic logic [NUM_W-1:0] pick_den();
        case ($urandom_range(11))
            0:       return '0;
            1, 2:    return $urandom;
            3:       return 32'd1 << $urandom_range(31);
            4:       return 32'hFFFF_FFFF;
            default: return 32'($urandom_range(60, 1));
        endcase
    endfunction

    function automatic logic [ACT_W-1:0] pick_action();
        if ($urandom_range(49) == 0) return $urandom_range(1) ? ACT_RSVD6 : ACT_RSVD7;
        return ACT_W'($urandom_range(ACT_CMP));
    endfunction

    task automatic test_directed();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_operands(ACT_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
        send_operands(ACT_SUB, 32'd1, 32'd2, 32'd1, 32'd3);
        send_operands(ACT_MUL, 32'd3, 32'd4, -32'sd5, 32'd7);
        send_operands(ACT_DIV, 32'd3, 32'd4, -32'sd5, 32'd7);
        send_operands(ACT_RED, -32'sd12, 32'd18, 32'd0, 32'd1);
        send_operands(ACT_CMP, 32'd1, 32'd3, 32'd1, 32'd2);
        send_operands(ACT_CMP, 32'd2, 32'd4, 32'd1, 32'd2);
        send_operands(ACT_CMP, 32'd2, 32'd3, 32'd1, 32'd2);
        // zero denominators on add, compare and subtract
        send_operands(ACT_ADD, 32'd5, 32'd0, 32'd1, 32'd3);
        send_operands(ACT_CMP, 32'd5, 32'd7, 32'd1, 32'd0);
        send_operands(ACT_SUB, 32'd5, 32'd0, 32'd1, 32'd0);
        // product denominator wraps to zero; zero divisor numerator and zero reduce denominators
        send_operands(ACT_MUL, 32'd3, 32'h0001_0000, 32'd5, 32'h0001_0000);
        send_operands(ACT_DIV, 32'd3, 32'd4, 32'd0, 32'd9);
        send_operands(ACT_RED, -32'sd7, 32'd0, 32'd0, 32'd0);
        send_operands(ACT_RED, 32'd0, 32'd0, 32'd0, 32'd0);
        // most negative numerator
        send_operands(ACT_RED, 32'h8000_0000, 32'd2, 32'd0, 32'd0);
        send_operands(ACT_DIV, 32'd3, 32'd4, 32'h8000_0000, 32'd1);
        send_operands(ACT_ADD, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_operands(ACT_MUL, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        // consecutive Fibonacci denominators: longest gcd
        send_operands(ACT_ADD, 32'd1, 32'd2971215073, 32'd1, 32'd1836311903);
        send_operands(ACT_CMP, 32'h7FFF_FFFF, 32'd1836311903, 32'h8000_0000, 32'd2971215073);
        send_operands(ACT_RED, 32'd1836311903, 32'd2971215073, 32'd0, 32'd0);
        send_operands(ACT_RSVD6, 32'd1, 32'd2, 32'd3, 32'd4);
        send_operands(ACT_RSVD7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        end_stream();
    endtask

    task automatic test_random(int count, int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < count; i++)
            send_operands(pick_action(), pick_num(), pick_den(), pick_num(), pick_den());
        end_stream();
    endtask

    // output held off long enough that the unit backs up onto its input
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_request = 600;
        for (int i = 0; i < 12; i++)
            send_operands(ACT_W'($urandom_range(ACT_CMP)), 32'($urandom_range(40)) - 32'd20,
                          32'($urandom_range(30, 1)), 32'($urandom_range(40)) - 32'd20,
                          32'($urandom_range(30, 1)));
        end_stream();
    endtask

    always @(negedge aclk) begin
        if (stall_request > 0) begin
            stall_left    = stall_request;
            stall_request = 0;
        end
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        rational_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("beat with nothing pending", m_tdata[31:0], '0);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[31:0] !== want.r_num)
                    report_mismatch("r_num", m_tdata[31:0], want.r_num);
                if (m_tdata[63:32] !== want.r_den)
                    report_mismatch("r_den", m_tdata[63:32], want.r_den);
                if (m_tdata[65:64] !== want.order)
                    report_mismatch("order", 32'(m_tdata[65:64]), 32'(want.order));
                if (m_tuser !== want.err)
                    report_mismatch("zero_den_error", 32'(m_tuser), 32'(want.err));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random(190, 24, 79);
        test_random(190, 79, 24);
        test_backpressure();
        test_random(190, 0, 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
